FILE: src/memory_access_order_queue_macros.svh
// Assertion macros for the memory access order queue.
`ifndef MEMORY_ACCESS_ORDER_QUEUE_MACROS_SVH
`define MEMORY_ACCESS_ORDER_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
`define MAOQ_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("maoq check failed");
`define MAOQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("maoq check failed");
`else
`define MAOQ_ASSERT_IMPL(label, clk, rst_n, a, b)
`define MAOQ_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: src/maoq_pkg.sv
// Shared types and constants of the memory access order queue.
package maoq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int OCC_W     = 5;

    localparam logic [3:0] OP_INSERT   = 4'd0;
    localparam logic [3:0] OP_SET_ADDR = 4'd1;
    localparam logic [3:0] OP_NO_ADDR  = 4'd2;
    localparam logic [3:0] OP_REMOVE   = 4'd3;
    localparam logic [3:0] OP_FREE_SEQ = 4'd4;
    localparam logic [3:0] OP_FREE_LVL = 4'd5;
    localparam logic [3:0] OP_FLUSH    = 4'd6;
    localparam logic [3:0] OP_EVAL     = 4'd7;
    localparam logic [3:0] OP_CLEAR    = 4'd8;
    localparam logic [3:0] OP_QUERY    = 4'd9;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    // flag bit positions
    localparam int F_WR   = 0;
    localparam int F_TRED = 1;
    localparam int F_TST  = 2;
    localparam int F_WAIT = 3;
    localparam int F_AKN  = 4;

    localparam logic [31:0] NO_ADDR = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]  seq;
        logic [3:0]  level;
        logic        dep_flag;
        logic [7:0]  dep_seq;
        logic [4:0]  flags;
        logic [31:0] addr;
        logic [31:0] hi;
        logic [31:0] lo;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic more;
        logic rd_pending;
        logic out_free;
    } stat_t;

    function automatic logic entry_pending(input logic [4:0] f);
        return f[F_TRED] ? f[F_TST] : f[F_WR];
    endfunction

endpackage

FILE: src/maoq_ctrl.sv
// Sequencer of the memory access order queue: accept, scan, finish.
module maoq_ctrl
    import maoq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stat.more && !stat.rd_pending)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_SCAN:
            begin
                cmd.step = stat.more;
            end
            ST_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: src/maoq_dpath.sv
// Entry memory, scan/compaction pipeline and result register.
module maoq_dpath
    import maoq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [3:0]  opcode,
    input  logic [7:0]  seq_num,
    input  logic [3:0]  branch_level,
    input  logic        writes_memory,
    input  logic        trace_redundant,
    input  logic        trace_has_store,
    input  logic        branch_dependent,
    input  logic [7:0]  dep_seq,
    input  logic [31:0] mem_addr,
    input  logic [31:0] hi_value,
    input  logic [31:0] lo_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        entry_ready,
    output logic        entry_waiting,
    output logic        entry_addr_known,
    output logic [31:0] entry_addr,
    output logic [31:0] entry_hi,
    output logic [31:0] entry_lo,
    output logic        store_pending,
    output logic [OCC_W-1:0] occupancy
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    entry_t mem [DEPTH];
    entry_t mem_q;

    // latched input word
    logic [3:0]  op_reg;
    logic [7:0]  seq_reg;
    logic [3:0]  lvl_reg;
    logic        wr_reg, tred_reg, tst_reg, bdep_reg;
    logic [7:0]  dseq_reg;
    logic [31:0] addr_reg, hi_reg, lo_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] wr_idx_reg;
    logic             rd_valid_reg;
    logic             found_reg;
    logic             first_reg;
    logic             ev_go_reg;
    logic             pend_reg;
    logic [4:0]       last_flags_reg;
    logic             out_valid_reg;

    logic        q_ready_reg, q_wait_reg, q_akn_reg;
    logic [31:0] q_addr_reg, q_hi_reg, q_lo_reg;

    logic [1:0]  status_reg;
    logic        ready_o_reg, wait_o_reg, akn_o_reg, pend_o_reg;
    logic [31:0] addr_o_reg, hi_o_reg, lo_o_reg;

    entry_t e_mod;
    entry_t new_e;
    logic   keep;
    logic   match;
    logic   ev_go_next;
    logic   full;
    logic   do_ins;
    logic   free_go;

    assign stat.more       = (rd_idx_reg < count_reg);
    assign stat.rd_pending = rd_valid_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign full   = (count_reg >= DEPTH_C);
    assign do_ins = (op_reg == OP_INSERT) && !full;

    // per-entry operation on the word coming out of memory
    always_comb
    begin
        e_mod      = mem_q;
        keep       = 1'b1;
        match      = (mem_q.seq == seq_reg) && !found_reg;
        ev_go_next = ev_go_reg;
        case (op_reg)
            OP_SET_ADDR:
            begin
                if (match)
                begin
                    e_mod.addr         = addr_reg;
                    e_mod.hi           = hi_reg;
                    e_mod.lo           = lo_reg;
                    e_mod.flags[F_AKN] = 1'b1;
                end
            end
            OP_NO_ADDR:
            begin
                if (match)
                begin
                    e_mod.addr         = NO_ADDR;
                    e_mod.hi           = '0;
                    e_mod.lo           = '0;
                    e_mod.flags[F_AKN] = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                keep = !match;
            end
            OP_FREE_SEQ:
            begin
                if (mem_q.seq > seq_reg)
                begin
                    e_mod.seq = mem_q.seq - 8'd1;
                end
                if (mem_q.dep_flag && (mem_q.dep_seq > seq_reg))
                begin
                    e_mod.dep_seq = mem_q.dep_seq - 8'd1;
                end
            end
            OP_FREE_LVL:
            begin
                if (mem_q.level > lvl_reg)
                begin
                    e_mod.level = mem_q.level - 4'd1;
                end
            end
            OP_FLUSH:
            begin
                keep = (mem_q.level <= lvl_reg);
            end
            OP_EVAL:
            begin
                // head always released; then release up to the first write
                if (first_reg)
                begin
                    e_mod.flags[F_WAIT] = 1'b0;
                    ev_go_next          = !mem_q.flags[F_WR];
                end
                else if (ev_go_reg)
                begin
                    if (mem_q.flags[F_WR])
                    begin
                        ev_go_next = 1'b0;
                    end
                    else
                    begin
                        e_mod.flags[F_WAIT] = 1'b0;
                    end
                end
            end
            default:
            begin
                keep = 1'b1;
            end
        endcase
    end

    assign free_go = (count_reg == '0) ||
                     (!last_flags_reg[F_WAIT] && !last_flags_reg[F_WR] && !wr_reg);

    always_comb
    begin
        new_e.seq      = seq_reg;
        new_e.level    = lvl_reg;
        new_e.dep_flag = bdep_reg;
        new_e.dep_seq  = dseq_reg;
        new_e.flags    = {1'b0, !free_go, tst_reg, tred_reg, wr_reg};
        new_e.addr     = '0;
        new_e.hi       = '0;
        new_e.lo       = '0;
    end

    // memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        mem_q <= mem[rd_idx_reg[IDX_W-1:0]];
        if (rd_valid_reg && keep)
        begin
            mem[wr_idx_reg[IDX_W-1:0]] <= e_mod;
        end
        else if (cmd.finish && do_ins)
        begin
            mem[count_reg[IDX_W-1:0]] <= new_e;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            first_reg     <= 1'b1;
            ev_go_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.step;
            if (cmd.load)
            begin
                rd_idx_reg <= '0;
                wr_idx_reg <= '0;
                found_reg  <= 1'b0;
                first_reg  <= 1'b1;
                ev_go_reg  <= 1'b0;
                pend_reg   <= 1'b0;
            end
            if (cmd.step)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (rd_valid_reg)
            begin
                first_reg <= 1'b0;
                ev_go_reg <= ev_go_next;
                if (match)
                begin
                    found_reg <= 1'b1;
                end
                if (keep)
                begin
                    wr_idx_reg <= wr_idx_reg + 1'b1;
                    pend_reg   <= pend_reg | entry_pending(e_mod.flags);
                end
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (op_reg == OP_CLEAR)
                begin
                    count_reg <= '0;
                end
                else
                begin
                    count_reg <= wr_idx_reg + CNT_W'(do_ins);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= opcode;
            seq_reg     <= seq_num;
            lvl_reg     <= branch_level;
            wr_reg      <= writes_memory;
            tred_reg    <= trace_redundant;
            tst_reg     <= trace_has_store;
            bdep_reg    <= branch_dependent;
            dseq_reg    <= dep_seq;
            addr_reg    <= mem_addr;
            hi_reg      <= hi_value;
            lo_reg      <= lo_value;
            q_ready_reg <= 1'b0;
            q_wait_reg  <= 1'b0;
            q_akn_reg   <= 1'b0;
            q_addr_reg  <= '0;
            q_hi_reg    <= '0;
            q_lo_reg    <= '0;
        end
        if (rd_valid_reg)
        begin
            last_flags_reg <= e_mod.flags;
            if (match && (op_reg == OP_QUERY))
            begin
                q_ready_reg <= !mem_q.flags[F_WAIT] && (mem_q.level == 4'd0) &&
                               mem_q.flags[F_AKN];
                q_wait_reg  <= mem_q.flags[F_WAIT];
                q_akn_reg   <= mem_q.flags[F_AKN];
                q_addr_reg  <= mem_q.addr;
                q_hi_reg    <= mem_q.hi;
                q_lo_reg    <= mem_q.lo;
            end
        end
        if (cmd.finish)
        begin
            ready_o_reg <= q_ready_reg;
            wait_o_reg  <= q_wait_reg;
            akn_o_reg   <= q_akn_reg;
            addr_o_reg  <= q_addr_reg;
            hi_o_reg    <= q_hi_reg;
            lo_o_reg    <= q_lo_reg;
            if (op_reg == OP_CLEAR)
            begin
                pend_o_reg <= 1'b0;
            end
            else
            begin
                pend_o_reg <= pend_reg | (do_ins && entry_pending(new_e.flags));
            end
            if ((op_reg == OP_INSERT) && full)
            begin
                status_reg <= STAT_FULL;
            end
            else if (((op_reg == OP_SET_ADDR) || (op_reg == OP_NO_ADDR) ||
                      (op_reg == OP_REMOVE) || (op_reg == OP_QUERY)) && !found_reg)
            begin
                status_reg <= STAT_NOT_FOUND;
            end
            else
            begin
                status_reg <= STAT_DONE;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign entry_ready      = ready_o_reg;
    assign entry_waiting    = wait_o_reg;
    assign entry_addr_known = akn_o_reg;
    assign entry_addr       = addr_o_reg;
    assign entry_hi         = hi_o_reg;
    assign entry_lo         = lo_o_reg;
    assign store_pending    = pend_o_reg;
    assign occupancy        = OCC_W'(count_reg);

endmodule

FILE: src/memory_access_order_queue.sv
// Memory access order queue: entries kept in program order, head first.
// Input channel (in_valid/in_stall) takes one operation word: an opcode
// with sequence number, level, flags and address/data words.
// Output channel (out_valid/out_stall) returns one result word per
// operation: status, queried entry fields, store_pending and occupancy.
// Every operation walks all occupied entries through a memory with one read
// and one write port, one entry per cycle, rewriting and compacting in place.
// The result word appears once the entry walk is done, and the input
// reopens in the same cycle.
// A result waits in an output register, so the next word is accepted while
// the receiver stalls; a second result is held back until the first leaves.
// Reset empties the queue and drops any result in flight; entry storage is
// not cleared, only entries below the occupancy are ever read.
module memory_access_order_queue
    import maoq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  opcode,
    input  logic [7:0]  seq_num,
    input  logic [3:0]  branch_level,
    input  logic        writes_memory,
    input  logic        trace_redundant,
    input  logic        trace_has_store,
    input  logic        branch_dependent,
    input  logic [7:0]  dep_seq,
    input  logic [31:0] mem_addr,
    input  logic [31:0] hi_value,
    input  logic [31:0] lo_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        entry_ready,
    output logic        entry_waiting,
    output logic        entry_addr_known,
    output logic [31:0] entry_addr,
    output logic [31:0] entry_hi,
    output logic [31:0] entry_lo,
    output logic        store_pending,
    output logic [OCC_W-1:0] occupancy
);

`include "memory_access_order_queue_macros.svh"

    cmd_t  cmd;
    stat_t stat;

    maoq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    maoq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .opcode           (opcode),
        .seq_num          (seq_num),
        .branch_level     (branch_level),
        .writes_memory    (writes_memory),
        .trace_redundant  (trace_redundant),
        .trace_has_store  (trace_has_store),
        .branch_dependent (branch_dependent),
        .dep_seq          (dep_seq),
        .mem_addr         (mem_addr),
        .hi_value         (hi_value),
        .lo_value         (lo_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .entry_ready      (entry_ready),
        .entry_waiting    (entry_waiting),
        .entry_addr_known (entry_addr_known),
        .entry_addr       (entry_addr),
        .entry_hi         (entry_hi),
        .entry_lo         (entry_lo),
        .store_pending    (store_pending),
        .occupancy        (occupancy)
    );

    `MAOQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `MAOQ_ASSERT_IMPL(a_full_occ, clk, rst_n, out_valid && (status == STAT_FULL),
        occupancy == OCC_W'(DEPTH))
    `MAOQ_ASSERT_IMPL(a_notfound_empty, clk, rst_n,
        out_valid && (status == STAT_NOT_FOUND),
        !entry_ready && !entry_addr_known && (entry_addr == 32'd0))
    `MAOQ_ASSERT_IMPL(a_ready_known, clk, rst_n, out_valid && entry_ready,
        entry_addr_known && !entry_waiting)

endmodule
